/* src/tbc_pkg.sv */
// shared widths, register indexes and latencies for the barycentric color block
package tbc_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int NW_W       = DET_W + 2;
    localparam int NUM_W      = NW_W + 8;
    localparam int CHAN_W     = 8;
    localparam int NUM_REGS   = 6;
    localparam int ADDR_W     = 3;

    // one stage for sign and scale, one for the overflow test, one per quotient bit
    localparam int DIV_LAT    = 2 + CHAN_W;
    // four front stages, the divider, the output register
    localparam int PIPE_LAT   = 4 + DIV_LAT + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef enum logic [ADDR_W-1:0] {
        REG_AX = 3'd0,
        REG_AY = 3'd1,
        REG_BX = 3'd2,
        REG_BY = 3'd3,
        REG_CX = 3'd4,
        REG_CY = 3'd5
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

/* src/tbc_div.sv */
// pipelined weight channel: clamp(num * 255 / det) with one quotient bit per stage
module tbc_div
    import tbc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [NW_W-1:0]   num,
    input  logic signed [DET_W-1:0]  den,
    output logic [CHAN_W-1:0]        chan
);

    // stage a: signs, magnitudes, scale by 255
    logic [NUM_W-1:0]  a_num_reg;
    logic [DET_W-1:0]  a_den_reg;
    logic              a_zero_reg;
    logic [NW_W-1:0]   mag_num;
    logic [DET_W-1:0]  mag_den;

    assign mag_num = num[NW_W-1] ? NW_W'(-num) : NW_W'(num);
    assign mag_den = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);

    always_ff @(posedge clk)
    begin
        a_num_reg  <= (NUM_W'(mag_num) << 8) - NUM_W'(mag_num);
        a_den_reg  <= mag_den;
        // opposite signs truncate to zero or go negative, both clamp to zero
        a_zero_reg <= (num == '0) || (num[NW_W-1] != den[DET_W-1]);
    end

    // stage b: quotient of 256 or more clamps high
    logic [NUM_W-1:0]  rem_reg  [0:CHAN_W];
    logic [DET_W-1:0]  d_reg    [0:CHAN_W];
    logic [CHAN_W-1:0] q_reg    [0:CHAN_W];
    logic              zero_reg [0:CHAN_W];
    logic              over_reg [0:CHAN_W];

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= a_num_reg;
        d_reg[0]    <= a_den_reg;
        q_reg[0]    <= '0;
        zero_reg[0] <= a_zero_reg;
        over_reg[0] <= a_num_reg >= (NUM_W'(a_den_reg) << CHAN_W);
    end

    for (genvar i = 0; i < CHAN_W; i++)
    begin : g_step
        logic [NUM_W-1:0] trial;
        logic             fit;

        assign trial = NUM_W'(d_reg[i]) << (CHAN_W - 1 - i);
        assign fit   = rem_reg[i] >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= fit ? rem_reg[i] - trial : rem_reg[i];
            q_reg[i+1]    <= {q_reg[i][CHAN_W-2:0], fit};
            d_reg[i+1]    <= d_reg[i];
            zero_reg[i+1] <= zero_reg[i];
            over_reg[i+1] <= over_reg[i];
        end
    end

    assign chan = zero_reg[CHAN_W] ? '0 :
                  over_reg[CHAN_W] ? CHAN_MAX : q_reg[CHAN_W];

endmodule

/* src/triangle_barycentric_color.sv */
// barycentric color of one pixel against a configured triangle
//
// One pixel is taken every clock (busy stays low) and its ARGB word comes out
// on done in order; the depth is set by four arithmetic stages (differences,
// products, sums, third weight), ten divider stages (sign and scale, overflow
// test, then eight that resolve one quotient bit each), and the output
// register. Results cannot be held off. Vertex registers are written through
// cfg_we, cfg_addr and cfg_wdata; the user must write them only while no
// pixel is in flight, which the block does not enforce. Index 6 and 7 are
// ignored. A zero-area triangle gives color 0 with degenerate set.
module triangle_barycentric_color
    import tbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    output logic                   done,
    output logic [31:0]            argb_color,
    output logic                   degenerate,
    input  logic                   cfg_we,
    input  logic [ADDR_W-1:0]      cfg_addr,
    input  logic [COORD_BITS-1:0]  cfg_wdata
);

    coord_t vert_reg [0:NUM_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                vert_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_addr < ADDR_W'(NUM_REGS)))
        begin
            vert_reg[cfg_addr] <= coord_t'(cfg_wdata);
        end
    end

    assign busy = 1'b0;

    // valid bits for front stages and divider
    logic v_reg [0:PIPE_LAT-2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT - 1; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= start;
            for (int i = 1; i < PIPE_LAT - 1; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] s1_bycy_reg, s1_axcx_reg, s1_cxbx_reg;
    logic signed [DIFF_W-1:0] s1_aycy_reg, s1_cyay_reg, s1_pxcx_reg, s1_pycy_reg;

    always_ff @(posedge clk)
    begin
        s1_bycy_reg <= DIFF_W'(vert_reg[REG_BY]) - DIFF_W'(vert_reg[REG_CY]);
        s1_axcx_reg <= DIFF_W'(vert_reg[REG_AX]) - DIFF_W'(vert_reg[REG_CX]);
        s1_cxbx_reg <= DIFF_W'(vert_reg[REG_CX]) - DIFF_W'(vert_reg[REG_BX]);
        s1_aycy_reg <= DIFF_W'(vert_reg[REG_AY]) - DIFF_W'(vert_reg[REG_CY]);
        s1_cyay_reg <= DIFF_W'(vert_reg[REG_CY]) - DIFF_W'(vert_reg[REG_AY]);
        s1_pxcx_reg <= DIFF_W'(pixel_x) - DIFF_W'(vert_reg[REG_CX]);
        s1_pycy_reg <= DIFF_W'(pixel_y) - DIFF_W'(vert_reg[REG_CY]);
    end

    // stage 2: products
    logic signed [PROD_W-1:0] s2_d0_reg, s2_d1_reg, s2_u0_reg, s2_u1_reg;
    logic signed [PROD_W-1:0] s2_v0_reg, s2_v1_reg;

    always_ff @(posedge clk)
    begin
        s2_d0_reg <= PROD_W'(s1_bycy_reg) * PROD_W'(s1_axcx_reg);
        s2_d1_reg <= PROD_W'(s1_cxbx_reg) * PROD_W'(s1_aycy_reg);
        s2_u0_reg <= PROD_W'(s1_bycy_reg) * PROD_W'(s1_pxcx_reg);
        s2_u1_reg <= PROD_W'(s1_cxbx_reg) * PROD_W'(s1_pycy_reg);
        s2_v0_reg <= PROD_W'(s1_cyay_reg) * PROD_W'(s1_pxcx_reg);
        s2_v1_reg <= PROD_W'(s1_axcx_reg) * PROD_W'(s1_pycy_reg);
    end

    // stage 3: determinant and numerators
    logic signed [DET_W-1:0] s3_det_reg, s3_nu_reg, s3_nv_reg;

    always_ff @(posedge clk)
    begin
        s3_det_reg <= DET_W'(s2_d0_reg) + DET_W'(s2_d1_reg);
        s3_nu_reg  <= DET_W'(s2_u0_reg) + DET_W'(s2_u1_reg);
        s3_nv_reg  <= DET_W'(s2_v0_reg) + DET_W'(s2_v1_reg);
    end

    // stage 4: third weight
    logic signed [DET_W-1:0] s4_det_reg;
    logic signed [NW_W-1:0]  s4_nu_reg, s4_nv_reg, s4_nw_reg;
    logic                    s4_dz_reg;

    always_ff @(posedge clk)
    begin
        s4_det_reg <= s3_det_reg;
        s4_nu_reg  <= NW_W'(s3_nu_reg);
        s4_nv_reg  <= NW_W'(s3_nv_reg);
        s4_nw_reg  <= NW_W'(s3_det_reg) - NW_W'(s3_nu_reg) - NW_W'(s3_nv_reg);
        s4_dz_reg  <= (s3_det_reg == '0);
    end

    logic [CHAN_W-1:0] red, green, blue;

    tbc_div u_div_r (.clk(clk), .num(s4_nu_reg), .den(s4_det_reg), .chan(red));
    tbc_div u_div_g (.clk(clk), .num(s4_nv_reg), .den(s4_det_reg), .chan(green));
    tbc_div u_div_b (.clk(clk), .num(s4_nw_reg), .den(s4_det_reg), .chan(blue));

    logic dz_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        dz_reg[0] <= s4_dz_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            dz_reg[i] <= dz_reg[i-1];
        end
    end

    logic        done_reg;
    logic [31:0] argb_reg;
    logic        degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_reg[PIPE_LAT-2];
        end
    end

    always_ff @(posedge clk)
    begin
        degen_reg <= dz_reg[DIV_LAT-1];
        argb_reg  <= dz_reg[DIV_LAT-1] ? 32'd0 : {CHAN_MAX, red, green, blue};
    end

    assign done       = done_reg;
    assign argb_color = argb_reg;
    assign degenerate = degen_reg;

endmodule

/* src/tbc_checker.sv */
// port-level checks for the barycentric color block and their bind
module tbc_checker
    import tbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] argb_color,
    input logic        degenerate
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("beat lost");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("unrequested result beat");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (argb_color == 32'd0))
        else $error("degenerate color not zero");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate) |-> (argb_color[31:24] == CHAN_MAX))
        else $error("alpha not opaque");

endmodule

bind triangle_barycentric_color tbc_checker u_tbc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .argb_color(argb_color),
    .degenerate(degenerate)
);

/* tb/tb_triangle_barycentric_color.sv */
// self-checking testbench for the barycentric color block
module tb_triangle_barycentric_color;
    import tbc_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic done;
    logic [31:0] argb_color;
    logic degenerate;
    logic cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [COORD_BITS-1:0] cfg_wdata;

    typedef struct packed {
        logic [31:0] color;
        logic        degen;
    } shade_t;

    localparam int STALL_LIMIT = 2000;

    coord_t vertex [NUM_REGS];
    shade_t shade_q [$];
    int     gap_pct;
    bit     failed;
    int     idle_cycles;

    triangle_barycentric_color uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done),
        .argb_color(argb_color), .degenerate(degenerate),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] weight_to_channel(longint num, longint det);
        longint q;
        q = (num * 255) / det;
        if (q < 0)
            return 8'd0;
        if (q > 255)
            return 8'd255;
        return q[7:0];
    endfunction

    function automatic shade_t shade_pixel(coord_t px, coord_t py);
        longint ax, ay, bx, by, cx, cy, x, y, det, nu, nv, nw;
        shade_t s;
        ax = vertex[REG_AX]; ay = vertex[REG_AY];
        bx = vertex[REG_BX]; by = vertex[REG_BY];
        cx = vertex[REG_CX]; cy = vertex[REG_CY];
        x = px;
        y = py;
        det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
        if (det == 0)
        begin
            s.color = 32'd0;
            s.degen = 1'b1;
            return s;
        end
        nu = (by - cy) * (x - cx) + (cx - bx) * (y - cy);
        nv = (cy - ay) * (x - cx) + (ax - cx) * (y - cy);
        nw = det - nu - nv;
        s.color = {8'hFF, weight_to_channel(nu, det), weight_to_channel(nv, det),
                   weight_to_channel(nw, det)};
        s.degen = 1'b0;
        return s;
    endfunction

    // result checker and stall watchdog
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (shade_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    want = shade_q.pop_front();
                    if (argb_color !== want.color)
                    begin
                        $error("argb_color expected %h got %h", want.color, argb_color);
                        failed = 1'b1;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $error("degenerate expected %b got %b", want.degen, degenerate);
                        failed = 1'b1;
                    end
                end
            end
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("tb_triangle_barycentric_color failed");
                $finish;
            end
        end
    end

    // start stays high after the beat so back-to-back beats need no second drive
    task automatic send_pixel(coord_t px, coord_t py);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shade_q.push_back(shade_pixel(px, py));
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (shade_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    // write enable stays high so consecutive writes need no second drive
    task automatic write_vertex(logic [ADDR_W-1:0] idx, logic [COORD_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        if (idx < NUM_REGS)
            vertex[idx] = val;
    endtask

    task automatic set_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                coord_t cx, coord_t cy);
        drain();
        write_vertex(REG_AX, ax);
        write_vertex(REG_AY, ay);
        write_vertex(REG_BX, bx);
        write_vertex(REG_BY, by);
        write_vertex(REG_CX, cx);
        write_vertex(REG_CY, cy);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_degenerate;
        // all vertices at zero after reset
        send_pixel(12'sd0, 12'sd0);
        send_pixel(12'sh7FF, 12'sh800);
    endtask

    task automatic test_directed;
        set_triangle(12'sd0, 12'sd0, 12'sd100, 12'sd0, 12'sd0, 12'sd100);
        send_pixel(12'sd0, 12'sd0);
        send_pixel(12'sd100, 12'sd0);
        send_pixel(12'sd0, 12'sd100);
        send_pixel(12'sd25, 12'sd25);
        send_pixel(12'sd33, 12'sd33);
        send_pixel(12'sh7FF, 12'sh7FF);
        send_pixel(12'sh800, 12'sh800);
        send_pixel(12'sh800, 12'sh7FF);
        send_pixel(-12'sd1, 12'sd50);
        // red falls below range and blue exceeds it while green stays in range
        send_pixel(12'sd10, 12'sd300);
        // extreme triangle, largest determinant
        set_triangle(12'sh800, 12'sh800, 12'sh7FF, 12'sh800, 12'sh800, 12'sh7FF);
        send_pixel(12'sd0, 12'sd0);
        send_pixel(12'sh7FF, 12'sh7FF);
        send_pixel(12'sh800, 12'sh800);
        send_pixel(12'sh800, 12'sh7FF);
        // reversed winding, negative determinant
        set_triangle(12'sd0, 12'sd0, 12'sd0, 12'sd100, 12'sd100, 12'sd0);
        send_pixel(12'sd20, 12'sd30);
        send_pixel(-12'sd20, 12'sd30);
        // collinear vertices
        set_triangle(12'sd1, 12'sd1, 12'sd2, 12'sd2, 12'sd3, 12'sd3);
        send_pixel(12'sd5, 12'sd7);
        // index beyond the register file is dropped
        drain();
        write_vertex(3'd6, 12'hABC);
        write_vertex(3'd7, 12'h123);
        cfg_we <= 1'b0;
        send_pixel(12'sd5, 12'sd7);
    endtask

    task automatic random_block(int n, int span);
        coord_t v [NUM_REGS];
        int lo;
        lo = -span;
        for (int k = 0; k < NUM_REGS; k++)
            v[k] = $urandom_range(9) == 0 ? coord_t'($urandom)
                                          : coord_t'($urandom_range(2 * span) + lo);
        set_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
        for (int i = 0; i < n; i++)
        begin
            // mostly pixels near the triangle, some anywhere
            if ($urandom_range(3) == 0)
                send_pixel(coord_t'($urandom), coord_t'($urandom));
            else
                send_pixel(coord_t'($urandom_range(2 * span) + lo),
                           coord_t'($urandom_range(2 * span) + lo));
        end
    endtask

    task automatic test_random(int pct);
        gap_pct = pct;
        for (int t = 0; t < 30; t++)
            random_block(20, t % 3 == 0 ? 2047 : (t % 3 == 1 ? 200 : 8));
        // hold off until the pipe is empty
        start <= 1'b0;
        while (shade_q.size() != 0)
            @(negedge clk);
        send_pixel(coord_t'($urandom), coord_t'($urandom));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        failed    = 1'b0;
        idle_cycles = 0;
        gap_pct   = 0;
        for (int k = 0; k < NUM_REGS; k++)
            vertex[k] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_degenerate();
        test_directed();
        test_random(23);
        test_random(70);
        test_random(0);
        drain();
        if (!failed)
            $display("tb_triangle_barycentric_color passed");
        else
            $display("tb_triangle_barycentric_color failed");
        $finish;
    end

endmodule

/* files.f */
src/tbc_pkg.sv
src/tbc_div.sv
src/triangle_barycentric_color.sv
src/tbc_checker.sv
tb/tb_triangle_barycentric_color.sv
